@@ hw/rtl/deq_pkg.sv @@
// Package: shared types and constants for the double-ended queue unit.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic [DATA_W-1:0] EMPTY_READ = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
    logic [STAT_W-1:0]        status;
  } deq_out_t;

  typedef struct packed {
    logic               done;
    logic               empty;
    logic               full;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } deq_ctl_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// Deque control: index and count update, status, and transaction sequencing.
`timescale 1ns / 1ps
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  deq_in_t                     cmd_i,
  output logic                        busy_o,
  output logic                        we_o,
  output logic [$clog2(CAPACITY)-1:0] waddr_o,
  output logic [DATA_W-1:0]           wdata_o,
  output logic                        re_o,
  output logic [$clog2(CAPACITY)-1:0] raddr_front_o,
  output logic [$clog2(CAPACITY)-1:0] raddr_back_o,
  output deq_ctl_t                    ctl_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);
  localparam logic [OW-1:0] FullCnt = OW'(CAPACITY);

  state_e        state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] back_q, back_d;
  logic [OW-1:0] occ_q, occ_d;
  status_e       status_q, status_d;

  logic          accept;
  logic          is_push, is_pop, is_empty, is_full;
  logic [IW-1:0] front_up, front_dn, back_up, back_dn;

  assign accept   = start && (state_q == ST_IDLE);
  assign is_push  = (cmd_i.kind == KIND_PUSH_BACK) || (cmd_i.kind == KIND_PUSH_FRONT);
  assign is_pop   = (cmd_i.kind == KIND_POP_FRONT) || (cmd_i.kind == KIND_POP_BACK);
  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == FullCnt);

  assign front_up = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_dn = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign back_up  = (back_q == LastIdx) ? '0 : back_q + 1'b1;
  assign back_dn  = (back_q == '0) ? LastIdx : back_q - 1'b1;

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    status_d = status_q;
    we_o     = 1'b0;
    waddr_o  = front_q;
    wdata_o  = cmd_i.value;
    if (accept) begin
      status_d = STATUS_OK;
      if (is_push && is_full) begin
        status_d = STATUS_OVERFLOW;
      end else if (is_pop && is_empty) begin
        status_d = STATUS_UNDERFLOW;
      end else if (is_push) begin
        we_o  = 1'b1;
        occ_d = occ_q + 1'b1;
        if (is_empty) begin
          back_d  = front_q;
          waddr_o = front_q;
        end else if (cmd_i.kind == KIND_PUSH_BACK) begin
          back_d  = back_up;
          waddr_o = back_up;
        end else begin
          front_d = front_dn;
          waddr_o = front_dn;
        end
      end else if (is_pop) begin
        occ_d = occ_q - 1'b1;
        if (occ_q == OW'(1)) begin
          back_d = front_q;
        end else if (cmd_i.kind == KIND_POP_FRONT) begin
          front_d = front_up;
        end else begin
          back_d = back_dn;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_READ;
      ST_READ: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b1;
    re_o   = 1'b0;
    ctl_o  = '{done: 1'b0, empty: is_empty, full: is_full, status: status_q,
               count: COUNT_W'(occ_q)};
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_READ: re_o = 1'b1;
      ST_RESP: ctl_o.done = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  assign raddr_front_o = front_q;
  assign raddr_back_o  = back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      occ_q    <= '0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      occ_q    <= occ_d;
      status_q <= status_d;
    end
  end

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values, top level.
// The result strobe done_o rises in ST_RESP, which follows ST_READ, the state
// of the registered read; the write is done at the accepting edge.
// A new transaction is taken only in ST_IDLE; busy stays high through the done_o
// cycle, set by the write, then registered read, of the entry memories.
// Reset empties the deque; entry memory contents are not cleared.
// The receiver cannot stall: each result is valid for the single done_o cycle.
`timescale 1ns / 1ps
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  deq_in_t  cmd_i,
  output logic     busy,
  output logic     done_o,
  output deq_out_t result_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [IW-1:0]     raddr_front, raddr_back;
  logic [DATA_W-1:0] rdata_front, rdata_back;
  deq_ctl_t          ctl;

  deq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .busy_o       (busy),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_front_o(raddr_front),
    .raddr_back_o (raddr_back),
    .ctl_o        (ctl)
  );

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram_front (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr_front),
    .rdata_o(rdata_front)
  );

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram_back (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr_back),
    .rdata_o(rdata_back)
  );

  assign done_o               = ctl.done;
  assign result_o.front_value = ctl.empty ? EMPTY_READ : rdata_front;
  assign result_o.back_value  = ctl.empty ? EMPTY_READ : rdata_back;
  assign result_o.count       = ctl.count;
  assign result_o.is_empty    = ctl.empty;
  assign result_o.is_full     = ctl.full;
  assign result_o.status      = ctl.status;

endmodule
